[design/ctr_pkg.sv]
// Shared types, constants and arithmetic helpers for the circle trajectory reference unit.
package ctr_pkg;

  localparam int CORDIC_STAGES_DEF = 16;
  localparam int FRAC_BITS_DEF     = 16;
  localparam int ATAN_ENTRIES      = 24;

  localparam logic [1:0] REG_RADIUS       = 2'd0;
  localparam logic [1:0] REG_ANGULAR_RATE = 2'd1;
  localparam logic [1:0] REG_HEIGHT       = 2'd2;

  localparam logic [23:0] RADIUS_RST       = 24'd65536;
  localparam logic [23:0] ANGULAR_RATE_RST = 24'd1048576;
  localparam logic [31:0] HEIGHT_RST       = 32'd65536;

  // round(2^32 / (2*pi))
  localparam logic [29:0] PHASE_K = 30'd683565276;
  // CORDIC start value, Q30
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

  // atan(2^-i) in 2^-32 turn units
  localparam logic [31:0] ATAN_TURNS [ATAN_ENTRIES] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
    32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
    32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  typedef struct packed {
    logic        [23:0] radius;
    logic signed [23:0] angular_rate;
    logic signed [31:0] height;
  } cfg_t;

  typedef struct packed {
    logic [31:0] val;
    logic        clip;
  } sat_t;

  // Round half up, then arithmetic shift right.
  function automatic logic signed [67:0] round_shift(input logic signed [67:0] v,
                                                      input int sh);
    logic signed [67:0] half;
    half = 68'sd0;
    if (sh == 0) begin
      return v;
    end
    half = 68'sd1 <<< (sh - 1);
    return (v + half) >>> sh;
  endfunction

  // Clip to signed 32 bits and report the clip.
  function automatic sat_t sat32(input logic signed [67:0] v);
    sat_t res;
    res.clip = 1'b0;
    res.val  = v[31:0];
    if (v > 68'sh0_0000_0000_7FFF_FFFF) begin
      res.val  = 32'h7FFF_FFFF;
      res.clip = 1'b1;
    end else if (v < -68'sh0_0000_0000_8000_0000) begin
      res.val  = 32'h8000_0000;
      res.clip = 1'b1;
    end
    return res;
  endfunction

endpackage

[design/ctr_phase.sv]
// Phase pipeline: time sample to 32-bit turn angle, three register stages.
module ctr_phase (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [31:0]       time_sample,
  input  ctr_pkg::cfg_t     cfg,
  output logic              turn_valid,
  output logic [31:0]       turn
);

  logic        v1_r, v2_r, v3_r;
  logic        neg1_r, neg2_r;
  logic [55:0] m_r;
  logic [53:0] ph_r;
  logic [61:0] pl_r;
  logic [31:0] turn_r;

  logic [23:0] abs_w;
  logic [55:0] m_nxt;
  logic [67:0] sum;
  logic [31:0] mag;
  logic [31:0] turn_nxt;

  always_comb begin
    abs_w    = cfg.angular_rate[23] ? 24'(-cfg.angular_rate) : 24'(cfg.angular_rate);
    m_nxt    = 56'(abs_w) * 56'(time_sample);
    // only bits 67:36 of m*K matter, the rest wraps away
    sum      = {ph_r[35:0], 32'd0} + {6'd0, pl_r};
    mag      = sum[67:36];
    turn_nxt = neg2_r ? 32'(-mag) : mag;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
    m_r    <= m_nxt;
    neg1_r <= cfg.angular_rate[23];
    ph_r   <= 54'(m_r[55:32]) * 54'(ctr_pkg::PHASE_K);
    pl_r   <= 62'(m_r[31:0]) * 62'(ctr_pkg::PHASE_K);
    neg2_r <= neg1_r;
    turn_r <= turn_nxt;
  end

  assign turn_valid = v3_r;
  assign turn       = turn_r;

endmodule

[design/ctr_cordic.sv]
// Rotation-mode CORDIC, one register stage per iteration plus fold and output stages.
module ctr_cordic #(
  parameter int CORDIC_STAGES = ctr_pkg::CORDIC_STAGES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               turn_valid,
  input  logic [31:0]        turn,
  output logic               trig_valid,
  output logic signed [33:0] sin_val,
  output logic signed [33:0] cos_val
);

  localparam int N = CORDIC_STAGES;

  logic              v_r    [N+1];
  logic              flip_r [N+1];
  logic signed [33:0] x_r   [N+1];
  logic signed [33:0] y_r   [N+1];
  logic signed [33:0] a_r   [N+1];
  logic              out_v_r;
  logic signed [33:0] sin_r, cos_r;

  logic signed [33:0] a_in, a_fold;
  logic               flip_nxt;

  // fold the angle into +-quarter turn, remember to negate
  always_comb begin
    a_in     = 34'(signed'(turn));
    a_fold   = a_in;
    flip_nxt = 1'b0;
    if (a_in > (34'sd1 <<< 30)) begin
      a_fold   = a_in - (34'sd1 <<< 31);
      flip_nxt = 1'b1;
    end else if (a_in < -(34'sd1 <<< 30)) begin
      a_fold   = a_in + (34'sd1 <<< 31);
      flip_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= N; i++) begin
        v_r[i] <= 1'b0;
      end
      out_v_r <= 1'b0;
    end else begin
      v_r[0] <= turn_valid;
      for (int i = 0; i < N; i++) begin
        v_r[i+1] <= v_r[i];
      end
      out_v_r <= v_r[N];
    end
    a_r[0]    <= a_fold;
    x_r[0]    <= ctr_pkg::CORDIC_GAIN;
    y_r[0]    <= 34'sd0;
    flip_r[0] <= flip_nxt;
    for (int i = 0; i < N; i++) begin
      flip_r[i+1] <= flip_r[i];
      if (a_r[i] >= 34'sd0) begin
        x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
        a_r[i+1] <= a_r[i] - $signed({2'b00, ctr_pkg::ATAN_TURNS[i]});
      end else begin
        x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
        a_r[i+1] <= a_r[i] + $signed({2'b00, ctr_pkg::ATAN_TURNS[i]});
      end
    end
    sin_r <= flip_r[N] ? -y_r[N] : y_r[N];
    cos_r <= flip_r[N] ? -x_r[N] : x_r[N];
  end

  assign trig_valid = out_v_r;
  assign sin_val    = sin_r;
  assign cos_val    = cos_r;

endmodule

[design/ctr_scale.sv]
// Output scaling: config-derived gains, six products, rounding and saturation.
module ctr_scale #(
  parameter int FRAC_BITS = ctr_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               trig_valid,
  input  logic signed [33:0] sin_val,
  input  logic signed [33:0] cos_val,
  input  ctr_pkg::cfg_t      cfg,
  output logic               res_valid,
  output logic [31:0]        pos_x,
  output logic [31:0]        pos_y,
  output logic [31:0]        pos_z,
  output logic [31:0]        vel_x,
  output logic [31:0]        vel_y,
  output logic [31:0]        acc_x,
  output logic [31:0]        acc_y,
  output logic               saturated
);

  localparam int SH_P = 46 - FRAC_BITS;
  localparam int SH_V = 50 - FRAC_BITS;
  localparam int Z_UP = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
  localparam int Z_DN = (FRAC_BITS >= 16) ? 0 : 16 - FRAC_BITS;

  logic signed [24:0] r_s;
  logic signed [48:0] wr_prod;
  logic signed [47:0] ww_prod;
  logic signed [52:0] rww_prod;
  logic signed [32:0] wr_r;
  logic signed [27:0] ww_r;
  logic signed [32:0] rww_r;

  logic               p_v_r;
  logic signed [66:0] p_rs_r, p_rc_r, p_wc_r, p_ws_r, p_qs_r, p_qc_r;

  ctr_pkg::sat_t      s_px, s_py, s_pz, s_vx, s_vy, s_ax, s_ay;
  logic signed [67:0] z_val;

  logic               out_v_r;
  logic [31:0]        px_r, py_r, pz_r, vx_r, vy_r, ax_r, ay_r;
  logic               sat_r;

  // gains depend on config only; settled long before an item reaches them
  always_comb begin
    r_s      = $signed({1'b0, cfg.radius});
    wr_prod  = cfg.angular_rate * r_s;
    ww_prod  = cfg.angular_rate * cfg.angular_rate;
    rww_prod = r_s * ww_r;
  end

  always_ff @(posedge clk) begin
    wr_r  <= 33'(ctr_pkg::round_shift(68'(wr_prod), 16));
    ww_r  <= 28'(ctr_pkg::round_shift(68'(ww_prod), 20));
    rww_r <= 33'(ctr_pkg::round_shift(68'(rww_prod), 20));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_v_r <= 1'b0;
    end else begin
      p_v_r <= trig_valid;
    end
    p_rs_r <= r_s * sin_val;
    p_rc_r <= r_s * cos_val;
    p_wc_r <= wr_r * cos_val;
    p_ws_r <= wr_r * sin_val;
    p_qs_r <= rww_r * sin_val;
    p_qc_r <= rww_r * cos_val;
  end

  always_comb begin
    if (FRAC_BITS >= 16) begin
      z_val = 68'(cfg.height) <<< Z_UP;
    end else begin
      z_val = ctr_pkg::round_shift(68'(cfg.height), Z_DN);
    end
    s_px = ctr_pkg::sat32(ctr_pkg::round_shift(68'(p_rs_r), SH_P));
    s_py = ctr_pkg::sat32(ctr_pkg::round_shift(68'(p_rc_r), SH_P));
    s_pz = ctr_pkg::sat32(z_val);
    s_vx = ctr_pkg::sat32(ctr_pkg::round_shift(68'(p_wc_r), SH_V));
    s_vy = ctr_pkg::sat32(ctr_pkg::round_shift(-68'(p_ws_r), SH_V));
    s_ax = ctr_pkg::sat32(ctr_pkg::round_shift(-68'(p_qs_r), SH_P));
    s_ay = ctr_pkg::sat32(ctr_pkg::round_shift(-68'(p_qc_r), SH_P));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= p_v_r;
    end
    px_r  <= s_px.val;
    py_r  <= s_py.val;
    pz_r  <= s_pz.val;
    vx_r  <= s_vx.val;
    vy_r  <= s_vy.val;
    ax_r  <= s_ax.val;
    ay_r  <= s_ay.val;
    sat_r <= s_px.clip | s_py.clip | s_pz.clip | s_vx.clip | s_vy.clip |
             s_ax.clip | s_ay.clip;
  end

  assign res_valid = out_v_r;
  assign pos_x     = px_r;
  assign pos_y     = py_r;
  assign pos_z     = pz_r;
  assign vel_x     = vx_r;
  assign vel_y     = vy_r;
  assign acc_x     = ax_r;
  assign acc_y     = ay_r;
  assign saturated = sat_r;

endmodule

[design/circle_trajectory_reference_unit.sv]
// Top level of the circle trajectory reference unit: config registers and pipeline.
//
//   channel  | handshake               | payload
//   ---------+-------------------------+----------------------------------------
//   request  | start / busy            | in_time_sample
//   result   | out_valid (one cycle)   | out_pos_x/y/z, out_vel_x/y,
//            |                         | out_acc_x/y, out_saturated
//   config   | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// A request is taken every cycle; busy is always low. Each result passes
// through three phase stages, a fold stage, one stage per CORDIC iteration,
// a sign stage, a product stage and a round/saturate stage. Results strobe
// for one cycle and cannot be held off, so nothing in the pipeline stalls.
// Reset (rst_n low, synchronous) clears the valid bits and loads the
// register defaults.
module circle_trajectory_reference_unit #(
  parameter int CORDIC_STAGES = ctr_pkg::CORDIC_STAGES_DEF,
  parameter int FRAC_BITS     = ctr_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_time_sample,
  output logic        out_valid,
  output logic [31:0] out_pos_x,
  output logic [31:0] out_pos_y,
  output logic [31:0] out_pos_z,
  output logic [31:0] out_vel_x,
  output logic [31:0] out_vel_y,
  output logic [31:0] out_acc_x,
  output logic [31:0] out_acc_y,
  output logic        out_saturated,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  ctr_pkg::cfg_t      cfg_r;
  logic               accept;
  logic               turn_valid;
  logic [31:0]        turn;
  logic               trig_valid;
  logic signed [33:0] sin_val, cos_val;

  // fully pipelined: never push back on requests or config writes
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start & ~busy;

  // config registers; an unknown index is dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.radius       <= ctr_pkg::RADIUS_RST;
      cfg_r.angular_rate <= ctr_pkg::ANGULAR_RATE_RST;
      cfg_r.height       <= ctr_pkg::HEIGHT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ctr_pkg::REG_RADIUS:       cfg_r.radius       <= cfg_data[23:0];
        ctr_pkg::REG_ANGULAR_RATE: cfg_r.angular_rate <= cfg_data[23:0];
        ctr_pkg::REG_HEIGHT:       cfg_r.height       <= cfg_data;
        default: ;
      endcase
    end
  end

  // time to turn angle
  ctr_phase u_phase (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (accept),
    .time_sample (in_time_sample),
    .cfg         (cfg_r),
    .turn_valid  (turn_valid),
    .turn        (turn)
  );

  // turn angle to sin/cos
  ctr_cordic #(
    .CORDIC_STAGES (CORDIC_STAGES)
  ) u_cordic (
    .clk        (clk),
    .rst_n      (rst_n),
    .turn_valid (turn_valid),
    .turn       (turn),
    .trig_valid (trig_valid),
    .sin_val    (sin_val),
    .cos_val    (cos_val)
  );

  // scale by radius and rate, round, clip
  ctr_scale #(
    .FRAC_BITS (FRAC_BITS)
  ) u_scale (
    .clk        (clk),
    .rst_n      (rst_n),
    .trig_valid (trig_valid),
    .sin_val    (sin_val),
    .cos_val    (cos_val),
    .cfg        (cfg_r),
    .res_valid  (out_valid),
    .pos_x      (out_pos_x),
    .pos_y      (out_pos_y),
    .pos_z      (out_pos_z),
    .vel_x      (out_vel_x),
    .vel_y      (out_vel_y),
    .acc_x      (out_acc_x),
    .acc_y      (out_acc_y),
    .saturated  (out_saturated)
  );

endmodule

[design/ctr_checker.sv]
// Port-level checker for the circle trajectory reference unit, with its bind.
module ctr_checker #(
  parameter int CORDIC_STAGES = ctr_pkg::CORDIC_STAGES_DEF
) (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid,
  input logic cfg_valid,
  input logic cfg_ready
);

  localparam int LAT = CORDIC_STAGES + 7;

  a_req_yields_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_valid)
    else $error("request produced no result at fixed latency");

  a_result_has_request: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy && rst_n, LAT))
    else $error("result without matching request");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result strobe after reset");

  a_cfg_taken: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("config write held off");

endmodule

bind circle_trajectory_reference_unit ctr_checker #(
  .CORDIC_STAGES (CORDIC_STAGES)
) u_ctr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready)
);

[verif/tb_top.sv]
// Testbench for the circle trajectory reference unit: directed table, random requests, predictor.
`timescale 1ns / 1ps

module tb_top;

  localparam int STAGES     = ctr_pkg::CORDIC_STAGES_DEF;
  localparam int LATENCY    = STAGES + 7;
  localparam int CYCLE_MAX  = 200000;
  localparam longint KPH    = 64'd683565276;
  localparam longint GAIN   = 64'sd652032874;

  // One trajectory sample as the result ports carry it.
  typedef struct {
    logic [31:0] pos_x, pos_y, pos_z, vel_x, vel_y, acc_x, acc_y;
    logic        sat;
    bit          z_typed;   // row of the table with pos_z typed in
    logic [31:0] z_value;
  } traj_t;

  // Stimulus table row: either a register write or a request.
  typedef struct {
    bit          is_cfg;
    logic [1:0]  idx;
    logic [31:0] val;
    bit          z_typed;
    logic [31:0] z_value;
  } row_t;

  logic        clk, rst_n, start, busy;
  logic [31:0] in_time_sample;
  logic        out_valid, out_saturated;
  logic [31:0] out_pos_x, out_pos_y, out_pos_z, out_vel_x, out_vel_y, out_acc_x, out_acc_y;
  logic        cfg_valid, cfg_ready;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  circle_trajectory_reference_unit dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_time_sample(in_time_sample),
    .out_valid(out_valid), .out_pos_x(out_pos_x), .out_pos_y(out_pos_y),
    .out_pos_z(out_pos_z), .out_vel_x(out_vel_x), .out_vel_y(out_vel_y),
    .out_acc_x(out_acc_x), .out_acc_y(out_acc_y), .out_saturated(out_saturated),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  ctr_pkg::cfg_t shadow_cfg;  // register copy as the block should hold it
  traj_t  pending_traj[$];   // expected samples, oldest first
  int     mismatches;
  int     cycles;
  bit     next_z_typed;
  logic [31:0] next_z_value;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Saturate to signed 32 bits, flag the clip.
  function automatic logic [31:0] clip32(input longint v, inout logic flag);
    if (v > 64'sd2147483647) begin
      flag = 1'b1;
      return 32'h7FFF_FFFF;
    end
    if (v < -64'sd2147483648) begin
      flag = 1'b1;
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  // Round half up, then floor shift.
  function automatic longint rnd_shr(input longint v, input int sh);
    if (sh == 0) return v;
    return (v + (64'sd1 <<< (sh - 1))) >>> sh;
  endfunction

  function automatic traj_t predict_traj(input ctr_pkg::cfg_t c, input logic [31:0] t);
    traj_t  p;
    longint r, w, h, sn, cs, x, y, a, dx, dy, wr, ww, rww;
    longint unsigned m, hi_part, lo_part, turn;
    bit     flip;
    logic   clip;
    r = longint'({8'd0, c.radius});
    w = longint'(c.angular_rate);
    h = longint'(c.height);
    clip = 1'b0;
    flip = 1'b0;
    // phase in turns: |w|*t times 2^32/(2*pi), truncated
    m = longint'(w < 0 ? -w : w) * longint'({32'd0, t});
    hi_part = (m >> 32) * KPH;
    lo_part = (m & 64'hFFFF_FFFF) * KPH;
    turn = (hi_part >> 4) + ((((hi_part & 64'd15) << 32) + lo_part) >> 36);
    if (w < 0) turn = 64'd0 - turn;
    turn = turn & 64'hFFFF_FFFF;
    // fold into +-quarter turn, then rotate
    a = turn[31] ? longint'(turn) - (64'sd1 <<< 32) : longint'(turn);
    if (a > (64'sd1 <<< 30)) begin
      a = a - (64'sd1 <<< 31);
      flip = 1'b1;
    end else if (a < -(64'sd1 <<< 30)) begin
      a = a + (64'sd1 <<< 31);
      flip = 1'b1;
    end
    x = GAIN;
    y = 0;
    for (int i = 0; i < STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (a >= 0) begin
        x = x - dx; y = y + dy; a = a - longint'({32'd0, ctr_pkg::ATAN_TURNS[i]});
      end else begin
        x = x + dx; y = y - dy; a = a + longint'({32'd0, ctr_pkg::ATAN_TURNS[i]});
      end
    end
    sn = flip ? -y : y;
    cs = flip ? -x : x;
    wr  = rnd_shr(w * r, 16);
    ww  = rnd_shr(w * w, 20);
    rww = rnd_shr(r * ww, 20);
    p.pos_x = clip32(rnd_shr(r * sn, 30), clip);
    p.pos_y = clip32(rnd_shr(r * cs, 30), clip);
    p.pos_z = clip32(h, clip);
    p.vel_x = clip32(rnd_shr(wr * cs, 34), clip);
    p.vel_y = clip32(rnd_shr(-(wr * sn), 34), clip);
    p.acc_x = clip32(rnd_shr(-(rww * sn), 30), clip);
    p.acc_y = clip32(rnd_shr(-(rww * cs), 30), clip);
    p.sat = clip;
    p.z_typed = 1'b0;
    p.z_value = '0;
    return p;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycles);
    mismatches++;
  endtask

  // Sample at the rising edge: track register writes, predict accepted requests,
  // check strobed results against the oldest expectation.
  always @(posedge clk) begin
    traj_t e;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          ctr_pkg::REG_RADIUS:       shadow_cfg.radius       <= cfg_data[23:0];
          ctr_pkg::REG_ANGULAR_RATE: shadow_cfg.angular_rate <= cfg_data[23:0];
          ctr_pkg::REG_HEIGHT:       shadow_cfg.height       <= cfg_data;
          default: ;
        endcase
      end
      if (start && !busy) begin
        e = predict_traj(shadow_cfg, in_time_sample);
        e.z_typed = next_z_typed;
        e.z_value = next_z_value;
        pending_traj.push_back(e);
      end
      if (out_valid) begin
        if (pending_traj.size() == 0) begin
          report_mismatch("unexpected result", out_pos_x, 32'h0);
        end else begin
          e = pending_traj.pop_front();
          if (out_pos_x !== e.pos_x) report_mismatch("pos_x", out_pos_x, e.pos_x);
          if (out_pos_y !== e.pos_y) report_mismatch("pos_y", out_pos_y, e.pos_y);
          if (out_pos_z !== e.pos_z) report_mismatch("pos_z", out_pos_z, e.pos_z);
          if (out_vel_x !== e.vel_x) report_mismatch("vel_x", out_vel_x, e.vel_x);
          if (out_vel_y !== e.vel_y) report_mismatch("vel_y", out_vel_y, e.vel_y);
          if (out_acc_x !== e.acc_x) report_mismatch("acc_x", out_acc_x, e.acc_x);
          if (out_acc_y !== e.acc_y) report_mismatch("acc_y", out_acc_y, e.acc_y);
          if (out_saturated !== e.sat)
            report_mismatch("saturated", {31'd0, out_saturated}, {31'd0, e.sat});
          if (e.z_typed && out_pos_z !== e.z_value)
            report_mismatch("pos_z typed", out_pos_z, e.z_value);
        end
      end
    end
  end

  // Hard stop if the run hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_MAX) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Present one request at the falling edge and hold it until taken.
  task automatic send_request(input logic [31:0] t);
    @(negedge clk);
    start <= 1'b1;
    in_time_sample <= t;
    do @(posedge clk); while (busy);
  endtask

  task automatic hold_off(input int n);
    repeat (n) begin
      @(negedge clk);
      start <= 1'b0;
      in_time_sample <= $urandom;
    end
  endtask

  // Drop start, wait for every expected result, then let the pipe empty.
  task automatic drain_pipe();
    hold_off(1);
    while (pending_traj.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // Registers change only with the block idle.
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    drain_pipe();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] rand_time();
    case ($urandom_range(0, 5))
      0:       return $urandom_range(0, 65536 * 8);
      1:       return 32'hFFFF_FFFF - $urandom_range(0, 255);
      default: return $urandom;
    endcase
  endfunction

  row_t table_rows[$];

  initial begin
    int burst;
    rst_n = 1'b0;
    start = 1'b0;
    in_time_sample = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    mismatches = 0;
    cycles = 0;
    next_z_typed = 1'b0;
    next_z_value = '0;
    shadow_cfg.radius = ctr_pkg::RADIUS_RST;
    shadow_cfg.angular_rate = ctr_pkg::ANGULAR_RATE_RST;
    shadow_cfg.height = ctr_pkg::HEIGHT_RST;

    // After reset: height default shows on pos_z; time extremes and a wrap.
    table_rows = '{
      '{0, ctr_pkg::REG_RADIUS, 32'h0000_0000, 1, 32'h0001_0000},
      '{0, ctr_pkg::REG_RADIUS, 32'hFFFF_FFFF, 1, 32'h0001_0000},
      '{0, ctr_pkg::REG_RADIUS, 32'h0001_0000, 1, 32'h0001_0000},
      '{0, ctr_pkg::REG_RADIUS, 32'h0006_487F, 1, 32'h0001_0000},
      // largest radius, rate and height
      '{1, ctr_pkg::REG_RADIUS,       32'hFFFF_FFFF, 0, 0},
      '{1, ctr_pkg::REG_ANGULAR_RATE, 32'h007F_FFFF, 0, 0},
      '{1, ctr_pkg::REG_HEIGHT,       32'h7FFF_FFFF, 0, 0},
      '{0, ctr_pkg::REG_RADIUS, 32'h0000_0000, 1, 32'h7FFF_FFFF},
      '{0, ctr_pkg::REG_RADIUS, 32'h0001_8000, 1, 32'h7FFF_FFFF},
      '{0, ctr_pkg::REG_RADIUS, 32'hFFFF_FFFF, 1, 32'h7FFF_FFFF},
      // most negative rate, most negative height, upper data bits set
      '{1, ctr_pkg::REG_ANGULAR_RATE, 32'hFF80_0000, 0, 0},
      '{1, ctr_pkg::REG_HEIGHT,       32'h8000_0000, 0, 0},
      '{1, ctr_pkg::REG_RADIUS,       32'hAB00_0000, 0, 0},
      '{0, ctr_pkg::REG_RADIUS, 32'h0000_0001, 1, 32'h8000_0000},
      '{0, ctr_pkg::REG_RADIUS, 32'h1234_5678, 1, 32'h8000_0000},
      // unknown index leaves registers as they are
      '{1, 2'd3,                      32'h5555_5555, 0, 0},
      '{1, ctr_pkg::REG_RADIUS,       32'h0002_0000, 0, 0},
      '{1, ctr_pkg::REG_ANGULAR_RATE, 32'h0000_0000, 0, 0},
      '{0, ctr_pkg::REG_RADIUS, 32'hFFFF_FFFF, 1, 32'h8000_0000},
      '{1, ctr_pkg::REG_ANGULAR_RATE, 32'hFFF0_0000, 0, 0},
      '{0, ctr_pkg::REG_RADIUS, 32'h0000_8000, 0, 0},
      '{0, ctr_pkg::REG_RADIUS, 32'h0003_0000, 0, 0},
      '{0, ctr_pkg::REG_RADIUS, 32'hFFFF_FFFF, 0, 0}
    };

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (table_rows[i]) begin
      if (table_rows[i].is_cfg) begin
        write_reg(table_rows[i].idx, table_rows[i].val);
      end else begin
        next_z_typed = table_rows[i].z_typed;
        next_z_value = table_rows[i].z_value;
        send_request(table_rows[i].val);
      end
    end
    drain_pipe();
    next_z_typed = 1'b0;

    // Random phases: new settings each time, bursty requests.
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(ctr_pkg::REG_RADIUS, (ph == 3) ? 32'h00FF_FFFF : $urandom);
      write_reg(ctr_pkg::REG_ANGULAR_RATE, (ph == 5) ? 32'h0080_0000 : $urandom);
      write_reg(ctr_pkg::REG_HEIGHT, $urandom);
      for (int k = 0; k < 50; k += burst) begin
        burst = $urandom_range(1, 12);
        for (int b = 0; b < burst; b++) send_request(rand_time());
        // every third phase runs with no gaps at all
        if (ph % 3 != 2) hold_off($urandom_range(0, 9));
        if (ph == 4 && k < 12 && k + burst >= 12) drain_pipe();
      end
    end

    drain_pipe();
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
